// ===== rtl/core/hsf_pkg.sv =====
// Package: shared types and constants of the half/single float converter.
package hsf_pkg;

    localparam int unsigned ValueWidth = 32;

    localparam logic [7:0]  S2hSubMin  = 8'd102;
    localparam logic [7:0]  S2hNormMin = 8'd113;
    localparam logic [7:0]  S2hInfMin  = 8'd143;
    localparam logic [7:0]  S2hShBase  = 8'd126;
    localparam logic [7:0]  Rebias     = 8'd112;
    localparam logic [7:0]  H2sSubBase = 8'd113;
    localparam logic [7:0]  ExpAll32   = 8'hff;
    localparam logic [4:0]  ExpAll16   = 5'h1f;
    localparam logic [14:0] Inf16      = 15'h7c00;

    typedef enum logic [1:0] {
        KD_ZERO,
        KD_SUB,
        KD_NORM,
        KD_INF
    } t_kind;

    typedef enum logic {
        ACT_S2H = 1'b0,
        ACT_H2S = 1'b1
    } t_act;

    typedef struct packed {
        t_act        act;
        logic        sign;
        t_kind       kind;
        logic [7:0]  exp;
        logic [23:0] mant;
        logic [4:0]  shamt;
    } t_dec;

    typedef struct packed {
        t_act        act;
        logic        sign;
        t_kind       kind;
        logic [7:0]  exp;
        logic [22:0] frac;
        logic        rnd;
    } t_shf;

    typedef struct packed {
        t_act                  act;
        logic [ValueWidth-1:0] bits;
    } t_res;

endpackage

// ===== rtl/core/hsf_if.sv =====
// Interfaces: input and output word channels of the converter.
interface hsf_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] value_bits;

    modport source (output valid, output action, output value_bits, input ready);
    modport sink   (input valid, input action, input value_bits, output ready);
endinterface

interface hsf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;

    modport source (output valid, output result_bits, input ready);
    modport sink   (input valid, input result_bits, output ready);
endinterface

// ===== rtl/core/half_single_float_converter.sv =====
// Top level: three-stage half/single precision float converter.
//
//  channel  dir  fields                     handshake
//  i_in     in   action, value_bits         valid/ready
//  o_out    out  result_bits                valid/ready
//
// One word per cycle while o_out is not stalled; an accepted word passes through the
// decode, shift and pack registers before it is offered on o_out.
// Latency is set by the decode, shift and pack register stages.
// All stages advance together when the output register is empty or taken.
// Synchronous active-low reset clears the stage valid bits only.
module half_single_float_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hsf_in_if.sink        i_in,
    hsf_out_if.source     o_out
);
    logic          en;
    logic          v1;
    logic          v2;
    logic          v3;
    hsf_pkg::t_dec dec;
    hsf_pkg::t_shf shf;
    hsf_pkg::t_res res;

    assign en         = !v3 || o_out.ready;
    assign i_in.ready = en;

    hsf_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in.valid),
        .i_action (i_in.action),
        .i_value  (i_in.value_bits),
        .o_valid  (v1),
        .o_dec    (dec)
    );

    hsf_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v1),
        .i_dec   (dec),
        .o_valid (v2),
        .o_shf   (shf)
    );

    hsf_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v2),
        .i_shf   (shf),
        .o_valid (v3),
        .o_res   (res)
    );

    assign o_out.valid       = v3;
    assign o_out.result_bits = res.bits;

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!o_out.valid || o_out.ready))
        else $error("input ready does not follow output stall");

    a_half_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v3 && res.act == hsf_pkg::ACT_S2H) |-> (res.bits[31:16] == 16'd0))
        else $error("half result has upper bits set");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v1 && !en) |=> (v1 && $stable(dec)))
        else $error("decode stage changed during stall");
endmodule

// ===== rtl/core/hsf_decode.sv =====
// Stage 1: classify the source word and find shift amounts.
module hsf_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic              i_action,
    input  logic [31:0]       i_value,
    output logic              o_valid,
    output hsf_pkg::t_dec     o_dec
);
    hsf_pkg::t_dec n_dec;
    hsf_pkg::t_dec r_dec;
    logic          r_valid;
    logic [7:0]    e8;
    logic [4:0]    e5;
    logic [9:0]    m10;
    logic [3:0]    lz;

    assign e8  = i_value[30:23];
    assign e5  = i_value[14:10];
    assign m10 = i_value[9:0];

    always_comb begin
        lz = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m10[i]) begin
                lz = 4'(10 - i);
            end
        end
    end

    always_comb begin
        n_dec       = '0;
        n_dec.act   = hsf_pkg::t_act'(i_action);
        if (i_action == hsf_pkg::ACT_H2S) begin
            n_dec.sign = i_value[15];
            n_dec.mant = {14'd0, m10};
            if (e5 == 5'd0) begin
                if (m10 == 10'd0) begin
                    n_dec.kind = hsf_pkg::KD_ZERO;
                end else begin
                    n_dec.kind  = hsf_pkg::KD_SUB;
                    n_dec.exp   = hsf_pkg::H2sSubBase - {4'd0, lz};
                    n_dec.shamt = {1'b0, lz};
                end
            end else if (e5 == hsf_pkg::ExpAll16) begin
                n_dec.kind = hsf_pkg::KD_INF;
                n_dec.exp  = hsf_pkg::ExpAll32;
            end else begin
                n_dec.kind = hsf_pkg::KD_NORM;
                n_dec.exp  = {3'd0, e5} + hsf_pkg::Rebias;
            end
        end else begin
            n_dec.sign = i_value[31];
            if (e8 < hsf_pkg::S2hSubMin) begin
                n_dec.kind = hsf_pkg::KD_ZERO;
            end else if (e8 < hsf_pkg::S2hNormMin) begin
                n_dec.kind  = hsf_pkg::KD_SUB;
                n_dec.mant  = {1'b1, i_value[22:0]};
                n_dec.shamt = 5'(hsf_pkg::S2hShBase - e8);
            end else if (e8 < hsf_pkg::S2hInfMin) begin
                n_dec.kind = hsf_pkg::KD_NORM;
                n_dec.exp  = e8 - hsf_pkg::Rebias;
                n_dec.mant = {1'b0, i_value[22:0]};
            end else begin
                n_dec.kind = hsf_pkg::KD_INF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
endmodule

// ===== rtl/core/hsf_shift.sv =====
// Stage 2: align mantissas and pick the round bit.
module hsf_shift (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  hsf_pkg::t_dec     i_dec,
    output logic              o_valid,
    output hsf_pkg::t_shf     o_shf
);
    hsf_pkg::t_shf n_shf;
    hsf_pkg::t_shf r_shf;
    logic          r_valid;
    logic [23:0]   sub_sh;
    logic [9:0]    norm_m;

    assign sub_sh = i_dec.mant >> (i_dec.shamt - 5'd1);
    assign norm_m = i_dec.mant[9:0] << i_dec.shamt;

    always_comb begin
        n_shf      = '0;
        n_shf.act  = i_dec.act;
        n_shf.sign = i_dec.sign;
        n_shf.kind = i_dec.kind;
        n_shf.exp  = i_dec.exp;
        if (i_dec.act == hsf_pkg::ACT_H2S) begin
            if (i_dec.kind == hsf_pkg::KD_SUB) begin
                n_shf.frac = {norm_m, 13'd0};
            end else begin
                n_shf.frac = {i_dec.mant[9:0], 13'd0};
            end
        end else if (i_dec.kind == hsf_pkg::KD_SUB) begin
            n_shf.frac = {8'd0, 4'd0, sub_sh[11:1]};
            n_shf.rnd  = sub_sh[0];
        end else begin
            n_shf.frac = {8'd0, i_dec.exp[4:0], i_dec.mant[22:13]};
            n_shf.rnd  = i_dec.mant[12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_shf <= n_shf;
        end
    end

    assign o_valid = r_valid;
    assign o_shf   = r_shf;
endmodule

// ===== rtl/core/hsf_pack.sv =====
// Stage 3: round and pack the result word.
module hsf_pack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  hsf_pkg::t_shf     i_shf,
    output logic              o_valid,
    output hsf_pkg::t_res     o_res
);
    hsf_pkg::t_res n_res;
    hsf_pkg::t_res r_res;
    logic          r_valid;

    always_comb begin
        n_res     = '0;
        n_res.act = i_shf.act;
        if (i_shf.act == hsf_pkg::ACT_H2S) begin
            if (i_shf.kind == hsf_pkg::KD_ZERO) begin
                n_res.bits = {i_shf.sign, 31'd0};
            end else begin
                n_res.bits = {i_shf.sign, i_shf.exp, i_shf.frac};
            end
        end else begin
            case (i_shf.kind)
                hsf_pkg::KD_ZERO: n_res.bits = {16'd0, i_shf.sign, 15'd0};
                hsf_pkg::KD_INF:  n_res.bits = {16'd0, i_shf.sign, hsf_pkg::Inf16};
                default: n_res.bits = {16'd0, i_shf.sign,
                                       i_shf.frac[14:0] + {14'd0, i_shf.rnd}};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

// ===== tb/tb.sv =====
// Testbench: random and directed conversion words checked against a behavioral converter.
module tb;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    hsf_in_if  in_ch ();
    hsf_out_if out_ch ();

    half_single_float_converter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    typedef struct packed {
        hsf_pkg::t_act act;
        logic [31:0]   bits;
    } t_word;

    t_word       pending_q[$];
    logic [31:0] result_q[$];
    int          n_err = 0;
    int          n_in = 0;
    int          n_out = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    bit          feed_done = 1'b0;
    bit          in_fire = 1'b0;

    function automatic logic [31:0] to_half(logic [31:0] x);
        logic [15:0] sgn;
        int          e;
        logic [23:0] m;
        logic [15:0] h;
        int          sh;
        sgn = {x[31], 15'd0};
        e = int'(x[30:23]) - 112;
        m = {1'b0, x[22:0]};
        if (e <= 0) begin
            if (e < -10) return {16'd0, sgn};
            m[23] = 1'b1;
            sh = 14 - e;
            h = 16'(m >> sh);
            if (m[sh-1]) h = h + 16'd1;
            return {16'd0, sgn | h};
        end
        if (e >= 31) return {16'd0, sgn | {1'b0, hsf_pkg::Inf16}};
        h = sgn | 16'(e << 10) | 16'(m[22:13]);
        if (m[12]) h = h + 16'd1;
        return {16'd0, h};
    endfunction

    function automatic logic [31:0] to_single(logic [31:0] v);
        logic [4:0]  e;
        logic [10:0] m;
        logic [7:0]  e32;
        e = v[14:10];
        m = {1'b0, v[9:0]};
        if (e == 5'd0) begin
            if (m == 11'd0) return {v[15], 31'd0};
            e32 = hsf_pkg::H2sSubBase;
            while (!m[10]) begin
                m = m << 1;
                e32 = e32 - 8'd1;
            end
            return {v[15], e32, m[9:0], 13'd0};
        end
        if (e == hsf_pkg::ExpAll16) return {v[15], hsf_pkg::ExpAll32, v[9:0], 13'd0};
        return {v[15], 8'(e) + hsf_pkg::Rebias, v[9:0], 13'd0};
    endfunction

    function automatic logic [31:0] convert(t_word w);
        return (w.act == hsf_pkg::ACT_H2S) ? to_single(w.bits) : to_half(w.bits);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        n_err++;
        $display("mismatch %s: result_bits got %08h want %08h", what, got, want);
    endtask

    task automatic add(hsf_pkg::t_act a, logic [31:0] b);
        t_word w;
        w.act = a;
        w.bits = b;
        pending_q = {pending_q, w};
    endtask

    function automatic logic [31:0] rand_single();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0: r[30:23] = 8'($urandom_range(102, 143));
            1: r[30:23] = 8'($urandom_range(110, 116));
            2: r[30:23] = 8'($urandom_range(140, 145));
            3: r[30:23] = 8'($urandom_range(99, 104));
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0) r[12:0] = {1'b1, 12'd0};
        if ($urandom_range(0, 7) == 0) r[22:12] = '1;
        return r;
    endfunction

    initial begin
        add(hsf_pkg::ACT_S2H, 32'h0000_0000);
        add(hsf_pkg::ACT_S2H, 32'h8000_0000);
        add(hsf_pkg::ACT_S2H, 32'h0000_0001);
        add(hsf_pkg::ACT_S2H, 32'h3f80_0000);
        add(hsf_pkg::ACT_S2H, 32'h477f_e000);
        add(hsf_pkg::ACT_S2H, 32'h477f_f000);
        add(hsf_pkg::ACT_S2H, 32'hc780_0000);
        add(hsf_pkg::ACT_S2H, 32'h7f80_0000);
        add(hsf_pkg::ACT_S2H, 32'hffc0_0001);
        add(hsf_pkg::ACT_S2H, 32'h3380_0000);
        add(hsf_pkg::ACT_S2H, 32'h3300_0000);
        add(hsf_pkg::ACT_S2H, 32'h387f_f000);
        add(hsf_pkg::ACT_S2H, 32'h3f80_1000);
        add(hsf_pkg::ACT_S2H, 32'hffff_ffff);
        add(hsf_pkg::ACT_H2S, 32'hffff_0000);
        add(hsf_pkg::ACT_H2S, 32'h0000_8000);
        add(hsf_pkg::ACT_H2S, 32'h0000_0001);
        add(hsf_pkg::ACT_H2S, 32'h0000_83ff);
        add(hsf_pkg::ACT_H2S, 32'h0000_3c00);
        add(hsf_pkg::ACT_H2S, 32'h0000_7bff);
        add(hsf_pkg::ACT_H2S, 32'h0000_7c00);
        add(hsf_pkg::ACT_H2S, 32'h0000_fe01);
        add(hsf_pkg::ACT_H2S, 32'hffff_ffff);
        for (int i = 0; i < 600; i++) begin
            if ($urandom_range(0, 1)) add(hsf_pkg::ACT_H2S, $urandom);
            else add(hsf_pkg::ACT_S2H, rand_single());
        end
        feed_done = 1'b1;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.value_bits = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_ch.valid || in_fire) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    burst_left--;
                    in_ch.valid <= 1'b1;
                    in_ch.action <= pending_q[0].act;
                    in_ch.value_bits <= pending_q[0].bits;
                    void'(pending_q.pop_front());
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(5, 60);
            end
            stall_left--;
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= $urandom_range(0, 1);
                default: out_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_word w;
        logic [31:0] want;
        if (i_rst_n) begin
            idle_cycles++;
            in_fire = in_ch.valid && in_ch.ready;
            if (in_fire) begin
                w.act = hsf_pkg::t_act'(in_ch.action);
                w.bits = in_ch.value_bits;
                result_q = {result_q, convert(w)};
                n_in++;
                idle_cycles = 0;
            end
            if (out_ch.valid && out_ch.ready) begin
                idle_cycles = 0;
                n_out++;
                if (result_q.size() == 0) begin
                    report("unexpected word", out_ch.result_bits, 32'd0);
                end else begin
                    want = result_q.pop_front();
                    if (out_ch.result_bits !== want)
                        report("value", out_ch.result_bits, want);
                end
            end
            if (idle_cycles >= 2000) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        wait (feed_done);
        while (!(pending_q.size() == 0 && !in_ch.valid && result_q.size() == 0))
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("converted %0d words in both directions, %0d results checked", n_in, n_out);
        if (n_err == 0 && result_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
